[src/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, request codes and width helpers for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Default number of list entries
  localparam int DEF_CAPACITY = 64;

  // Key width
  localparam int KEY_W = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_code_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Request transaction payload
  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
    logic [6:0]              position;
  } req_item_t;

  // Response transaction payload
  typedef struct packed {
    logic       req_ok;
    logic [5:0] position_out;
    logic [6:0] entry_count;
  } rsp_item_t;

  // Address width for a store of the given depth (at least one bit)
  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a counter that can hold the depth itself
  function automatic int count_w(int depth);
    return $clog2(depth + 1);
  endfunction

endpackage

[src/ple_ram.sv]
// ----------------------------------------------------------------------------
// ple_ram
// Simple dual-port key store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int DEPTH = ple_pkg::DEF_CAPACITY,
  localparam int AW = ple_pkg::addr_w(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ple_pkg::KEY_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [ple_pkg::KEY_W-1:0]  rdata
);
  import ple_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: scans the key store through its read port, moves entries
// up or down one slot per cycle and keeps the entry count.
// ----------------------------------------------------------------------------
module ple_ctrl #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY,
  localparam int AW = ple_pkg::addr_w(CAPACITY),
  localparam int CW = ple_pkg::count_w(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ple_pkg::req_item_t         req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ple_pkg::rsp_item_t         res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ple_pkg::KEY_W-1:0]  mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ple_pkg::KEY_W-1:0]  mem_rdata
);
  import ple_pkg::*;

  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             pend, pend_next;
  logic [1:0]       op, op_next;
  logic [KEY_W-1:0] key_r, key_next;
  logic [CW-1:0]    pos_r, pos_next;
  logic [CW-1:0]    sh, sh_next;
  logic [AW-1:0]    pend_idx, pend_idx_next;
  logic [AW-1:0]    where_r, where_next;
  rsp_item_t        res_r, res_next;

  logic             issue;
  logic             hit;
  logic [AW-1:0]    dst;

  assign res = res_r;

  // Next state and memory port control
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    pend_next     = 1'b0;
    op_next       = op;
    key_next      = key_r;
    pos_next      = pos_r;
    sh_next       = sh;
    pend_idx_next = pend_idx;
    where_next    = where_r;
    res_next      = res_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_idx;
    mem_wdata     = mem_rdata;
    mem_raddr     = sh[AW-1:0];
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    issue         = 1'b0;
    hit           = 1'b0;
    dst           = sh[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          key_next = req.key;
          op_next  = req.req_type;
          sh_next  = '0;
          case (req.req_type) inside
            REQ_SEARCH, REQ_DELETE: begin
              state_next = ST_SCAN;
            end
            REQ_INSERT: begin
              if (cnt < CAP_CW && CMPW'(req.position) <= CMPW'(cnt)) begin
                pos_next   = CW'(req.position);
                sh_next    = cnt;
                state_next = ST_SHIFT;
              end else begin
                res_next   = '{req_ok: 1'b0, position_out: '0, entry_count: 7'(cnt)};
                state_next = ST_DONE;
              end
            end
            default: begin
              res_next   = '{req_ok: 1'b0, position_out: '0, entry_count: 7'(cnt)};
              state_next = ST_DONE;
            end
          endcase
        end
      end

      // Stream reads from the bottom, compare each word when its read data returns
      ST_SCAN: begin
        issue = (sh < cnt);
        hit   = pend && (mem_rdata == key_r);
        if (hit) begin
          if (op == REQ_DELETE) begin
            where_next = pend_idx;
            sh_next    = CW'(pend_idx) + CW'(1);
            state_next = ST_SHIFT;
          end else begin
            res_next   = '{req_ok: 1'b1, position_out: 6'(pend_idx),
                           entry_count: 7'(cnt)};
            state_next = ST_DONE;
          end
        end else if (!issue) begin
          res_next   = '{req_ok: 1'b0, position_out: '0, entry_count: 7'(cnt)};
          state_next = ST_DONE;
        end else begin
          pend_next     = 1'b1;
          pend_idx_next = sh[AW-1:0];
          sh_next       = sh + CW'(1);
        end
      end

      // Move one entry per cycle: read source, write it one slot over next cycle
      ST_SHIFT: begin
        if (op == REQ_INSERT) begin
          issue     = (sh > pos_r);
          mem_raddr = AW'(sh - CW'(1));
          dst       = sh[AW-1:0];
        end else begin
          issue     = (sh < cnt);
          mem_raddr = sh[AW-1:0];
          dst       = AW'(sh - CW'(1));
        end
        if (pend) begin
          mem_we = 1'b1;
        end
        if (issue) begin
          pend_next     = 1'b1;
          pend_idx_next = dst;
          sh_next       = (op == REQ_INSERT) ? sh - CW'(1) : sh + CW'(1);
        end else if (!pend) begin
          if (op == REQ_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[AW-1:0];
            mem_wdata = key_r;
            cnt_next  = cnt + CW'(1);
            res_next  = '{req_ok: 1'b1, position_out: 6'(pos_r),
                          entry_count: 7'(cnt + CW'(1))};
          end else begin
            cnt_next  = cnt - CW'(1);
            res_next  = '{req_ok: 1'b1, position_out: 6'(where_r),
                          entry_count: 7'(cnt - CW'(1))};
          end
          state_next = ST_DONE;
        end
      end

      // Hold the result until the output register takes it
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    key_r    <= key_next;
    pos_r    <= pos_next;
    sh       <= sh_next;
    pend_idx <= pend_idx_next;
    where_r  <= where_next;
    res_r    <= res_next;
  end

endmodule

[src/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of 32-bit keys with search, insert-at-position and delete.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  req_item_t (req_type, key, position)
//  rsp       out        rsp_valid / rsp_ready  rsp_item_t (req_ok, position_out,
//                                              entry_count)
//
//  One request at a time. The key store has a single read port, so a scan or a
//  move handles one entry per cycle. Search scans from the bottom; insert moves
//  the entries at and above position up a slot, then writes the key; delete
//  scans, then moves the entries above the hit down. Rejected and unknown
//  requests go straight to the result. Reset clears the count; store contents
//  are not cleared. With rsp_ready low the output register holds its result;
//  the engine still takes one more request and holds its result until the register frees.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ple_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ple_pkg::rsp_item_t rsp
);
  import ple_pkg::*;

  localparam int AW = addr_w(CAPACITY);

  logic             res_valid;
  logic             res_ready;
  rsp_item_t        res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rdata;

  ple_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ple_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

[src/ple_checker.sv]
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input ple_pkg::req_item_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ple_pkg::rsp_item_t rsp
);
  import ple_pkg::*;

  // No response straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // One request in flight: ready drops after each accepted transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while engine busy");

  // A failed response carries position zero
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.req_ok) |-> (rsp.position_out == 6'd0))
    else $error("failed response with non-zero position");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
